### rtl/opca_pkg.sv
// Shared constants, types and helper functions of the off-screen pixmap cache allocator.
`default_nettype none
package opca_pkg;

    localparam int CACHE_ENTRIES = 256;
    localparam int ADDR_W        = $clog2(CACHE_ENTRIES);
    localparam int MAX_PLANES    = 24;
    localparam int PLANE_W       = $clog2(MAX_PLANES);
    localparam int HASH_SHIFT    = 8;
    localparam int SPARE_ROUNDS  = 4;
    localparam int FULL_ITERS    = MAX_PLANES + 1;

    localparam logic [10:0] BAND_TOP    = 11'd864;
    localparam logic [10:0] BAND_BOTTOM = 11'd2032;
    localparam logic [11:0] BAND_HEIGHT = 12'(BAND_BOTTOM - BAND_TOP);
    localparam logic [11:0] MAX_WIDTH   = 12'd1024;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ALL_PLANES = 2'd0;
    localparam logic [1:0] CFG_PLANE_CNT  = 2'd1;

    // Request types.
    localparam logic [1:0] REQ_CONFIRM = 2'd0;
    localparam logic [1:0] REQ_TEMP    = 2'd1;
    localparam logic [1:0] REQ_CANCEL  = 2'd2;
    localparam logic [1:0] REQ_PURGE   = 2'd3;

    // Result status codes.
    localparam logic [2:0] RES_DONE   = 3'd0;
    localparam logic [2:0] RES_HIT    = 3'd1;
    localparam logic [2:0] RES_LOAD   = 3'd2;
    localparam logic [2:0] RES_NODATA = 3'd3;
    localparam logic [2:0] RES_FAIL   = 3'd4;

    // Eviction mask sources.
    localparam logic [1:0] EV_REM   = 2'd0;
    localparam logic [1:0] EV_WORST = 2'd1;
    localparam logic [1:0] EV_ALL   = 2'd2;

    // Datapath operations.
    localparam logic [4:0] OP_NOP         = 5'd0;
    localparam logic [4:0] OP_CLR         = 5'd1;
    localparam logic [4:0] OP_LOAD        = 5'd2;
    localparam logic [4:0] OP_RD          = 5'd3;
    localparam logic [4:0] OP_LAT         = 5'd4;
    localparam logic [4:0] OP_SCAN_INIT_S = 5'd5;
    localparam logic [4:0] OP_SCAN_INIT_F = 5'd6;
    localparam logic [4:0] OP_SCAN_S      = 5'd7;
    localparam logic [4:0] OP_SCAN_F      = 5'd8;
    localparam logic [4:0] OP_DIV_INIT    = 5'd9;
    localparam logic [4:0] OP_DIV         = 5'd10;
    localparam logic [4:0] OP_EV_INIT     = 5'd11;
    localparam logic [4:0] OP_PG_INIT     = 5'd12;
    localparam logic [4:0] OP_SWEEP       = 5'd13;
    localparam logic [4:0] OP_EV_POST     = 5'd14;
    localparam logic [4:0] OP_COMMIT_S    = 5'd15;
    localparam logic [4:0] OP_COMMIT_F    = 5'd16;
    localparam logic [4:0] OP_FINAL       = 5'd17;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] evsel;
        logic [2:0] code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       single;
        logic       data;
        logic       hit;
        logic       bad;
        logic       clr_last;
        logic       scan_last;
        logic       div_done;
        logic       sweep_done;
        logic       ev_any;
        logic       fit_s;
        logic       fit_f;
        logic       cont;
        logic       out_free;
    } t_sts;

    // True when top - bottom >= h, with the difference taken as signed.
    function automatic logic fits(input logic [10:0] top, input logic [10:0] bottom,
                                  input logic [11:0] h);
        logic signed [12:0] diff;
        diff = $signed({2'b00, top}) - $signed({2'b00, bottom});
        return diff >= $signed({1'b0, h});
    endfunction

    function automatic logic [23:0] plane_bit(input logic [PLANE_W-1:0] p);
        return 24'(1) << p;
    endfunction

endpackage
`default_nettype wire

### rtl/opca_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module opca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/opca_ctrl.sv
// Controller state machine that sequences lookups, scans, evictions and commits.
`default_nettype none
module opca_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire opca_pkg::t_sts i_sts,
    output opca_pkg::t_cmd     o_cmd
);
    import opca_pkg::*;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_RD      = 5'd2;
    localparam logic [4:0] S_LAT     = 5'd3;
    localparam logic [4:0] S_DEC     = 5'd4;
    localparam logic [4:0] S_SSCAN_I = 5'd5;
    localparam logic [4:0] S_SSCAN   = 5'd6;
    localparam logic [4:0] S_SCHK    = 5'd7;
    localparam logic [4:0] S_DIV_I   = 5'd8;
    localparam logic [4:0] S_DIV     = 5'd9;
    localparam logic [4:0] S_SEV_CHK = 5'd10;
    localparam logic [4:0] S_SNEXT   = 5'd11;
    localparam logic [4:0] S_F_I     = 5'd12;
    localparam logic [4:0] S_FSCAN_I = 5'd13;
    localparam logic [4:0] S_FSCAN   = 5'd14;
    localparam logic [4:0] S_FCHK    = 5'd15;
    localparam logic [4:0] S_FCONT   = 5'd16;
    localparam logic [4:0] S_FEND    = 5'd17;
    localparam logic [4:0] S_FNEXT   = 5'd18;
    localparam logic [4:0] S_EV_I    = 5'd19;
    localparam logic [4:0] S_EV      = 5'd20;
    localparam logic [4:0] S_EV_P    = 5'd21;
    localparam logic [4:0] S_PG_I    = 5'd22;
    localparam logic [4:0] S_PG      = 5'd23;
    localparam logic [4:0] S_FIN     = 5'd24;

    logic [4:0] r_state, n_state;
    logic [4:0] r_ret, n_ret;
    logic [1:0] r_evsel, n_evsel;
    logic [2:0] r_code, n_code;
    logic [2:0] r_round, n_round;
    logic       r_att, n_att;
    logic [4:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
            r_evsel <= EV_ALL;
            r_code  <= RES_DONE;
            r_round <= '0;
            r_att   <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_evsel <= n_evsel;
            r_code  <= n_code;
            r_round <= n_round;
            r_att   <= n_att;
            r_iter  <= n_iter;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_evsel   = r_evsel;
        n_code    = r_code;
        n_round   = r_round;
        n_att     = r_att;
        n_iter    = r_iter;
        o_cmd.op    = OP_NOP;
        o_cmd.evsel = r_evsel;
        o_cmd.code  = r_code;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                o_cmd.op = OP_RD;
                n_state  = S_LAT;
            end
            S_LAT: begin
                o_cmd.op = OP_LAT;
                n_state  = S_DEC;
            end
            S_DEC: begin
                if (i_sts.req_type == REQ_CANCEL) begin
                    n_code  = RES_DONE;
                    n_state = S_FIN;
                end else if (i_sts.req_type == REQ_PURGE) begin
                    n_code  = RES_DONE;
                    n_state = S_PG_I;
                end else if (i_sts.hit) begin
                    n_code  = RES_HIT;
                    n_state = S_FIN;
                end else if (i_sts.bad) begin
                    n_code  = RES_FAIL;
                    n_state = S_FIN;
                end else if (i_sts.single) begin
                    n_round = '0;
                    n_state = S_SSCAN_I;
                end else begin
                    n_att   = 1'b0;
                    n_state = S_F_I;
                end
            end
            S_SSCAN_I: begin
                o_cmd.op = OP_SCAN_INIT_S;
                n_state  = S_SSCAN;
            end
            S_SSCAN: begin
                o_cmd.op = OP_SCAN_S;
                if (i_sts.scan_last) n_state = S_SCHK;
            end
            S_SCHK: begin
                if (i_sts.fit_s) begin
                    o_cmd.op = OP_COMMIT_S;
                    n_code   = i_sts.data ? RES_LOAD : RES_NODATA;
                    n_state  = S_FIN;
                end else if (r_round == 3'(SPARE_ROUNDS)) begin
                    n_code  = RES_FAIL;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIV_I;
                end
            end
            S_DIV_I: begin
                o_cmd.op = OP_DIV_INIT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_done) begin
                    n_evsel = EV_REM;
                    n_ret   = S_SEV_CHK;
                    n_state = S_EV_I;
                end
            end
            S_SEV_CHK: begin
                if (i_sts.ev_any) begin
                    n_round = r_round + 3'd1;
                    n_state = S_SSCAN_I;
                end else begin
                    n_evsel = EV_ALL;
                    n_ret   = S_SNEXT;
                    n_state = S_EV_I;
                end
            end
            S_SNEXT: begin
                n_round = r_round + 3'd1;
                n_state = S_SSCAN_I;
            end
            S_F_I: begin
                n_iter  = '0;
                n_state = S_FSCAN_I;
            end
            S_FSCAN_I: begin
                o_cmd.op = OP_SCAN_INIT_F;
                n_state  = S_FSCAN;
            end
            S_FSCAN: begin
                o_cmd.op = OP_SCAN_F;
                if (i_sts.scan_last) n_state = S_FCHK;
            end
            S_FCHK: begin
                if (i_sts.fit_f) begin
                    o_cmd.op = OP_COMMIT_F;
                    n_code   = i_sts.data ? RES_LOAD : RES_NODATA;
                    n_state  = S_FIN;
                end else begin
                    n_evsel = EV_WORST;
                    n_ret   = S_FCONT;
                    n_state = S_EV_I;
                end
            end
            S_FCONT: begin
                if (i_sts.cont && r_iter != 5'(FULL_ITERS)) begin
                    n_iter  = r_iter + 5'd1;
                    n_state = S_FSCAN_I;
                end else begin
                    n_state = S_FEND;
                end
            end
            S_FEND: begin
                if (i_sts.fit_f) begin
                    o_cmd.op = OP_COMMIT_F;
                    n_code   = i_sts.data ? RES_LOAD : RES_NODATA;
                    n_state  = S_FIN;
                end else begin
                    n_evsel = EV_ALL;
                    n_ret   = S_FNEXT;
                    n_state = S_EV_I;
                end
            end
            S_FNEXT: begin
                if (r_att) begin
                    n_code  = RES_FAIL;
                    n_state = S_FIN;
                end else begin
                    n_att   = 1'b1;
                    n_state = S_F_I;
                end
            end
            S_EV_I: begin
                o_cmd.op = OP_EV_INIT;
                n_state  = S_EV;
            end
            S_EV: begin
                o_cmd.op = OP_SWEEP;
                if (i_sts.sweep_done) n_state = S_EV_P;
            end
            S_EV_P: begin
                o_cmd.op = OP_EV_POST;
                n_state  = r_ret;
            end
            S_PG_I: begin
                o_cmd.op = OP_PG_INIT;
                n_state  = S_PG;
            end
            S_PG: begin
                o_cmd.op = OP_SWEEP;
                if (i_sts.sweep_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FINAL;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/opca_dpath.sv
// Datapath: entry store, plane marks, boundary, scan, divider, sweep and result register.
`default_nettype none
module opca_dpath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire opca_pkg::t_cmd i_cmd,
    output opca_pkg::t_sts      o_sts,
    input  wire logic           i_cfg_valid,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [23:0]    i_cfg_data,
    input  wire logic [1:0]     i_req_type,
    input  wire logic [31:0]    i_pixmap_id,
    input  wire logic           i_pixmap_present,
    input  wire logic           i_has_pixel_data,
    input  wire logic           i_single_plane,
    input  wire logic [11:0]    i_pix_width,
    input  wire logic [11:0]    i_pix_height,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [2:0]          o_status,
    output logic [10:0]         o_row_y,
    output logic [23:0]         o_plane_mask
);
    import opca_pkg::*;

    logic [23:0] r_apm;
    logic [4:0]  r_pcnt;
    logic [4:0]  w_n;

    logic [1:0]  r_type;
    logic [31:0] r_id;
    logic        r_present, r_data, r_single;
    logic [11:0] r_w, r_h;
    logic [ADDR_W-1:0] r_slot;

    logic [31:0] r_slot_tag;
    logic [23:0] r_cur_mask;
    logic [10:0] r_cur_row;

    logic [10:0] r_hw [MAX_PLANES];
    logic [10:0] r_bnd;

    logic [PLANE_W-1:0] r_sidx, r_best;
    logic [10:0]        r_val;
    logic               r_found;

    logic [31:0]        r_dq;
    logic [4:0]         r_dcnt;
    logic [PLANE_W-1:0] r_rem;
    logic [5:0]         w_dtmp;

    logic [ADDR_W:0]    r_sw_cnt;
    logic               r_sw_purge;
    logic [23:0]        r_ev_mask;
    logic [PLANE_W-1:0] r_ev_plane;
    logic               r_ev_all;
    logic               r_ev_any;
    logic               r_worst_moved;

    logic [ADDR_W-1:0]  r_clr_idx;

    logic [31:0] w_tag_rd;
    logic [23:0] w_mask_rd;
    logic [10:0] w_row_rd;

    logic              w_tag_we, w_mask_we, w_row_we;
    logic [ADDR_W-1:0] w_tag_wa, w_mask_wa, w_row_wa, w_raddr;
    logic [31:0]       w_tag_wd;
    logic [23:0]       w_mask_wd;
    logic [10:0]       w_row_wd;

    logic              w_sw_valid, w_sw_match;
    logic [ADDR_W-1:0] w_sw_addr;
    logic [10:0]       w_hw_sel;
    logic [23:0]       w_ev_m;
    logic [PLANE_W-1:0] w_ev_p;
    logic              w_keep;

    assign w_n = (r_pcnt == 5'd0) ? 5'd1 :
                 (r_pcnt > 5'(MAX_PLANES)) ? 5'(MAX_PLANES) : r_pcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apm  <= 24'hFF;
            r_pcnt <= 5'd8;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ALL_PLANES) r_apm <= i_cfg_data;
            else if (i_cfg_index == CFG_PLANE_CNT) r_pcnt <= i_cfg_data[4:0];
        end
    end

    opca_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_tags (
        .i_clk(i_clk), .i_we(w_tag_we), .i_waddr(w_tag_wa), .i_wdata(w_tag_wd),
        .i_raddr(w_raddr), .o_rdata(w_tag_rd)
    );
    opca_ram #(.WIDTH(24), .DEPTH(CACHE_ENTRIES)) u_masks (
        .i_clk(i_clk), .i_we(w_mask_we), .i_waddr(w_mask_wa), .i_wdata(w_mask_wd),
        .i_raddr(w_raddr), .o_rdata(w_mask_rd)
    );
    opca_ram #(.WIDTH(11), .DEPTH(CACHE_ENTRIES)) u_rows (
        .i_clk(i_clk), .i_we(w_row_we), .i_waddr(w_row_wa), .i_wdata(w_row_wd),
        .i_raddr(w_raddr), .o_rdata(w_row_rd)
    );

    assign w_raddr    = (i_cmd.op == OP_RD) ? r_slot : r_sw_cnt[ADDR_W-1:0];
    // The sweep reads one entry per beat and writes back the entry read on the previous beat.
    assign w_sw_valid = (i_cmd.op == OP_SWEEP) && (r_sw_cnt != '0);
    assign w_sw_addr  = ADDR_W'(r_sw_cnt - 1'b1);
    assign w_sw_match = r_sw_purge ? (w_tag_rd == r_id) : (w_mask_rd == r_ev_mask);
    assign w_hw_sel   = r_hw[r_sidx];

    always_comb begin
        w_tag_we  = 1'b0;
        w_tag_wa  = r_slot;
        w_tag_wd  = '0;
        w_mask_we = 1'b0;
        w_mask_wa = r_slot;
        w_mask_wd = '0;
        w_row_we  = 1'b0;
        w_row_wa  = r_slot;
        w_row_wd  = '0;
        case (i_cmd.op)
            OP_CLR: begin
                w_tag_we  = 1'b1;
                w_tag_wa  = r_clr_idx;
                w_mask_we = 1'b1;
                w_mask_wa = r_clr_idx;
                w_row_we  = 1'b1;
                w_row_wa  = r_clr_idx;
            end
            OP_SWEEP: begin
                w_tag_we  = w_sw_valid && w_sw_match;
                w_tag_wa  = w_sw_addr;
                w_mask_we = w_sw_valid && w_sw_match && !r_sw_purge;
                w_mask_wa = w_sw_addr;
            end
            OP_COMMIT_S: begin
                w_mask_we = 1'b1;
                w_mask_wd = plane_bit(r_best);
                w_row_we  = 1'b1;
                w_row_wd  = r_val - r_h[10:0];
            end
            OP_COMMIT_F: begin
                w_mask_we = 1'b1;
                w_mask_wd = r_apm;
                w_row_we  = 1'b1;
                w_row_wd  = r_bnd;
            end
            OP_FINAL: begin
                if (r_type == REQ_TEMP || r_type == REQ_CANCEL) begin
                    w_tag_we = 1'b1;
                end else if (r_type == REQ_CONFIRM && i_cmd.code == RES_LOAD) begin
                    w_tag_we = 1'b1;
                    w_tag_wd = r_id;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (i_cmd.evsel)
            EV_REM: begin
                w_ev_m = plane_bit(r_rem);
                w_ev_p = r_rem;
            end
            EV_WORST: begin
                w_ev_m = plane_bit(r_best);
                w_ev_p = r_best;
            end
            default: begin
                w_ev_m = r_apm;
                w_ev_p = r_best;
            end
        endcase
    end

    assign w_dtmp = {1'b0, r_rem} << 1 | 6'(r_dq[31]);
    assign w_keep = w_dtmp >= {1'b0, w_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd     <= BAND_TOP;
            r_clr_idx <= '0;
            for (int i = 0; i < MAX_PLANES; i++) r_hw[i] <= BAND_BOTTOM;
        end else begin
            case (i_cmd.op)
                OP_CLR: r_clr_idx <= r_clr_idx + 1'b1;
                OP_EV_POST: begin
                    if (r_ev_all) r_bnd <= BAND_TOP;
                    else r_hw[r_ev_plane] <= BAND_BOTTOM;
                end
                OP_COMMIT_S: r_hw[r_best] <= r_val - r_h[10:0];
                OP_COMMIT_F: r_bnd <= r_bnd + r_h[10:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_type    <= i_req_type;
                r_id      <= i_pixmap_id;
                r_present <= i_pixmap_present;
                r_data    <= i_has_pixel_data;
                r_single  <= i_single_plane;
                r_w       <= i_pix_width;
                r_h       <= i_pix_height;
                r_slot    <= ADDR_W'((i_pixmap_id >> HASH_SHIFT) ^ i_pixmap_id);
            end
            OP_LAT: begin
                r_slot_tag <= w_tag_rd;
                r_cur_mask <= w_mask_rd;
                r_cur_row  <= w_row_rd;
            end
            OP_SCAN_INIT_S: begin
                r_sidx  <= '0;
                r_best  <= '0;
                r_val   <= r_bnd;
                r_found <= 1'b0;
            end
            OP_SCAN_INIT_F: begin
                r_sidx <= '0;
                r_best <= '0;
                r_val  <= BAND_BOTTOM;
            end
            OP_SCAN_S: begin
                r_sidx <= r_sidx + 1'b1;
                if (w_hw_sel >= r_val) begin
                    r_best  <= r_sidx;
                    r_val   <= w_hw_sel;
                    r_found <= 1'b1;
                end
            end
            OP_SCAN_F: begin
                r_sidx <= r_sidx + 1'b1;
                if (w_hw_sel <= r_val) begin
                    r_best <= r_sidx;
                    r_val  <= w_hw_sel;
                end
            end
            OP_DIV_INIT: begin
                r_dq   <= r_slot_tag;
                r_dcnt <= '0;
                r_rem  <= '0;
            end
            OP_DIV: begin
                r_dq   <= r_dq << 1;
                r_dcnt <= r_dcnt + 5'd1;
                r_rem  <= w_keep ? PLANE_W'(w_dtmp - {1'b0, w_n}) : PLANE_W'(w_dtmp);
            end
            OP_EV_INIT: begin
                r_sw_cnt   <= '0;
                r_sw_purge <= 1'b0;
                r_ev_mask  <= w_ev_m;
                r_ev_plane <= w_ev_p;
                r_ev_all   <= (w_ev_m == r_apm);
                r_ev_any   <= 1'b0;
            end
            OP_PG_INIT: begin
                r_sw_cnt   <= '0;
                r_sw_purge <= 1'b1;
            end
            OP_SWEEP: begin
                r_sw_cnt <= r_sw_cnt + 1'b1;
                if (w_sw_valid && w_sw_match && !r_sw_purge) begin
                    r_ev_any <= 1'b1;
                    if (w_sw_addr == r_slot) r_slot_tag <= '0;
                end
            end
            OP_EV_POST: begin
                // The evicted plane's mark moves back to the band bottom unless the
                // mask was the full-depth one, which leaves that mark alone and resets the boundary to the band top.
                r_worst_moved <= !r_ev_all && (r_val != BAND_BOTTOM);
            end
            OP_COMMIT_S: begin
                r_cur_mask <= plane_bit(r_best);
                r_cur_row  <= r_val - r_h[10:0];
            end
            OP_COMMIT_F: begin
                r_cur_mask <= r_apm;
                r_cur_row  <= r_bnd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FINAL) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINAL) begin
            o_status <= i_cmd.code;
            if (i_cmd.code == RES_HIT || i_cmd.code == RES_LOAD
                    || i_cmd.code == RES_NODATA) begin
                o_row_y      <= r_cur_row;
                o_plane_mask <= r_cur_mask;
            end else begin
                o_row_y      <= '0;
                o_plane_mask <= '0;
            end
        end
    end

    always_comb begin
        o_sts.req_type   = r_type;
        o_sts.single     = r_single;
        o_sts.data       = r_data;
        o_sts.hit        = (r_slot_tag == r_id);
        o_sts.bad        = !r_present || (r_w > MAX_WIDTH) || (r_h > BAND_HEIGHT);
        o_sts.clr_last   = (r_clr_idx == ADDR_W'(CACHE_ENTRIES - 1));
        o_sts.scan_last  = (5'(r_sidx) == w_n - 5'd1);
        o_sts.div_done   = (r_dcnt == 5'd31);
        o_sts.sweep_done = (r_sw_cnt == (ADDR_W + 1)'(CACHE_ENTRIES));
        o_sts.ev_any     = r_ev_any;
        o_sts.fit_s      = r_found && fits(r_val, r_bnd, r_h);
        o_sts.fit_f      = fits(r_val, r_bnd, r_h);
        o_sts.cont       = !fits(r_val, r_bnd, r_h) && r_worst_moved;
        o_sts.out_free   = !o_out_valid || i_out_ready;
    end
endmodule
`default_nettype wire

### rtl/offscreen_pixmap_cache_allocator_unit.sv
// Top level of the off-screen pixmap cache allocator.
//
// Requests enter on the input channel (valid/ready), one beat per request, and each
// request gives exactly one result beat on the output channel. Configuration writes
// use their own channel, which is always ready; write only while the block is idle.
// After reset a pass clears all 256 entries of the entry store, during which
// o_in_ready stays low. A hit, a cancel or an oversized or non-present request goes
// from accept to result without a scan; any other miss adds a scan over the planes in use
// for each attempt, a tag remainder for single-plane eviction, and a sweep of the whole
// store for every eviction and for a purge, one entry per cycle through the memory port.
// One request is worked on at a time; the next one is accepted as soon as the
// previous result sits in the output register. When the receiver stalls, that
// result holds and the block finishes at most one further request before waiting.
`default_nettype none
module offscreen_pixmap_cache_allocator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_pixmap_id,
    input  wire logic        i_pixmap_present,
    input  wire logic        i_has_pixel_data,
    input  wire logic        i_single_plane,
    input  wire logic [11:0] i_pix_width,
    input  wire logic [11:0] i_pix_height,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [10:0]      o_row_y,
    output logic [23:0]      o_plane_mask
);
    import opca_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    opca_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    opca_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_type(i_req_type), .i_pixmap_id(i_pixmap_id),
        .i_pixmap_present(i_pixmap_present), .i_has_pixel_data(i_has_pixel_data),
        .i_single_plane(i_single_plane), .i_pix_width(i_pix_width),
        .i_pix_height(i_pix_height), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_status(o_status), .o_row_y(o_row_y),
        .o_plane_mask(o_plane_mask)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result issued while controller still busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == RES_FAIL || o_status == RES_DONE))
            |-> (o_row_y == '0 && o_plane_mask == '0))
        else $error("failed or done result carries row or mask");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= RES_FAIL))
        else $error("status code out of range");
endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the off-screen pixmap cache allocator unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import opca_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int HOLD_CYCLES  = 700;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] id;
        logic        present;
        logic        data;
        logic        single;
        logic [11:0] w;
        logic [11:0] h;
    } t_req;

    typedef struct {
        logic [2:0]  status;
        logic [10:0] row;
        logic [23:0] mask;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_ALL_PLANES;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [1:0]  req_type = REQ_CONFIRM;
    logic [31:0] pixmap_id = '0;
    logic        pixmap_present = 1'b0;
    logic        has_pixel_data = 1'b0;
    logic        single_plane = 1'b0;
    logic [11:0] pix_width = '0;
    logic [11:0] pix_height = '0;
    logic        out_ready = 1'b0;
    logic        cfg_ready, in_ready, out_valid;
    logic [2:0]  status;
    logic [10:0] row_y;
    logic [23:0] plane_mask;

    offscreen_pixmap_cache_allocator_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_req_type(req_type), .i_pixmap_id(pixmap_id),
        .i_pixmap_present(pixmap_present), .i_has_pixel_data(has_pixel_data),
        .i_single_plane(single_plane), .i_pix_width(pix_width),
        .i_pix_height(pix_height),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_status(status), .o_row_y(row_y), .o_plane_mask(plane_mask)
    );

    always #1 i_clk = ~i_clk;

    // Cache model state.
    logic [31:0] tag_mem [CACHE_ENTRIES];
    logic [23:0] mask_mem [CACHE_ENTRIES];
    logic [10:0] row_mem [CACHE_ENTRIES];
    int          high_water [MAX_PLANES];
    int          boundary;
    logic [23:0] all_mask;
    logic [4:0]  plane_cnt;

    t_req pending_reqs [$];
    t_res expected_results [$];
    int   issued = 0, accepted = 0, errors = 0, cycles = 0;
    int   status_seen [5];
    int   send_idle = 27, recv_idle = 80;
    int   hold_req = 0, hold_seen = 0, hold_left = 0;
    logic [31:0] id_pool [24];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic int planes_in_use();
        if (plane_cnt < 1) return 1;
        if (plane_cnt > MAX_PLANES) return MAX_PLANES;
        return int'(plane_cnt);
    endfunction

    function automatic logic [7:0] slot_of(input logic [31:0] id);
        return 8'((id >> 8) ^ id);
    endfunction

    function automatic int evict_mask(input logic [23:0] m);
        int count, b;
        count = 0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (mask_mem[i] == m) begin
                mask_mem[i] = '0;
                tag_mem[i] = '0;
                count++;
            end
        end
        if (m == all_mask) begin
            boundary = int'(BAND_TOP);
        end else begin
            b = 0;
            while (b < 31 && !(({8'd0, m} >> b) & 1)) b++;
            if (b < MAX_PLANES) high_water[b] = int'(BAND_BOTTOM);
        end
        return count;
    endfunction

    function automatic logic alloc_one_plane(input int slot, input int h);
        int n, best, lowv, p;
        logic found;
        n = planes_in_use();
        for (int round = 0; ; round++) begin
            best = 0;
            lowv = boundary;
            found = 1'b0;
            for (int ip = 0; ip < n; ip++) begin
                if (high_water[ip] >= lowv) begin
                    best = ip;
                    lowv = high_water[ip];
                    found = 1'b1;
                end
            end
            if (found && lowv - boundary >= h) begin
                mask_mem[slot] = 24'(1) << best;
                row_mem[slot] = 11'(lowv - h);
                high_water[best] -= h;
                return 1'b1;
            end
            if (round >= SPARE_ROUNDS) return 1'b0;
            p = int'(tag_mem[slot] % n);
            if (evict_mask(24'(1) << p) == 0) void'(evict_mask(all_mask));
        end
    endfunction

    function automatic logic alloc_all_planes(input int slot, input int h);
        int n, worst, hh;
        n = planes_in_use();
        for (int attempt = 0; attempt < 2; attempt++) begin
            worst = 0;
            hh = int'(BAND_BOTTOM);
            for (int it = 0; it <= MAX_PLANES + 1; it++) begin
                hh = int'(BAND_BOTTOM);
                worst = 0;
                for (int i = 0; i < n; i++) begin
                    if (high_water[i] <= hh) begin
                        worst = i;
                        hh = high_water[i];
                    end
                end
                if (hh - boundary >= h) break;
                void'(evict_mask(24'(1) << worst));
                if (!(hh - boundary < h && hh != high_water[worst])) break;
            end
            if (hh - boundary >= h) begin
                mask_mem[slot] = all_mask;
                row_mem[slot] = 11'(boundary);
                boundary += h;
                return 1'b1;
            end
            void'(evict_mask(all_mask));
        end
        return 1'b0;
    endfunction

    function automatic t_res predict_request(input t_req r);
        t_res res;
        int slot;
        logic ok;
        slot = int'(slot_of(r.id));
        res = '{RES_DONE, '0, '0};
        if (r.req == REQ_CANCEL) begin
            tag_mem[slot] = '0;
        end else if (r.req == REQ_PURGE) begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
                if (tag_mem[i] == r.id) tag_mem[i] = '0;
        end else begin
            if (tag_mem[slot] == r.id) begin
                res = '{RES_HIT, row_mem[slot], mask_mem[slot]};
            end else if (!r.present || r.w > MAX_WIDTH || r.h > BAND_HEIGHT) begin
                res.status = RES_FAIL;
            end else begin
                ok = r.single ? alloc_one_plane(slot, int'(r.h))
                              : alloc_all_planes(slot, int'(r.h));
                if (!ok) begin
                    res.status = RES_FAIL;
                end else begin
                    if (r.data) begin
                        tag_mem[slot] = r.id;
                        res.status = RES_LOAD;
                    end else begin
                        res.status = RES_NODATA;
                    end
                    res.row = row_mem[slot];
                    res.mask = mask_mem[slot];
                end
            end
            if (r.req == REQ_TEMP) tag_mem[slot] = '0;
        end
        return res;
    endfunction

    // Driver: a new beat is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        if (!(in_valid && accepted < issued)) begin
            if (i_rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                t_req r;
                r = pending_reqs.pop_front();
                in_valid <= 1'b1;
                req_type <= r.req;
                pixmap_id <= r.id;
                pixmap_present <= r.present;
                has_pixel_data <= r.data;
                single_plane <= r.single;
                pix_width <= r.w;
                pix_height <= r.h;
                issued <= issued + 1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // The long receiver hold-off runs on its own counter.
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end

    // Monitor: predict on each accepted request, check each result beat.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && in_valid && in_ready) begin
            t_req r;
            r = '{req_type, pixmap_id, pixmap_present, has_pixel_data, single_plane,
                  pix_width, pix_height};
            expected_results.push_back(predict_request(r));
            accepted <= accepted + 1;
        end
        if (i_rst_n && out_valid && out_ready) begin
            t_res e;
            if (expected_results.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                e = expected_results.pop_front();
                if (e.status <= RES_FAIL) status_seen[e.status]++;
                if (status !== e.status)
                    report($sformatf("status %0d, expected %0d", status, e.status));
                if (row_y !== e.row)
                    report($sformatf("row %0d, expected %0d", row_y, e.row));
                if (plane_mask !== e.mask)
                    report($sformatf("mask %h, expected %h", plane_mask, e.mask));
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == CFG_ALL_PLANES) all_mask = val;
        else if (idx == CFG_PLANE_CNT) plane_cnt = val[4:0];
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || accepted < issued || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic push_req(input logic [1:0] rq, input logic [31:0] id, input logic pr,
                            input logic dt, input logic sg, input logic [11:0] w,
                            input logic [11:0] h);
        pending_reqs.push_back('{rq, id, pr, dt, sg, w, h});
    endtask

    task automatic push_random(input int count, input int tall_pct);
        t_req r;
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            r.req = k < 50 ? REQ_CONFIRM : k < 65 ? REQ_TEMP : k < 85 ? REQ_CANCEL : REQ_PURGE;
            k = $urandom_range(99);
            r.id = k < 80 ? id_pool[$urandom_range(23)] : k < 83 ? 32'd0 : $urandom;
            r.present = $urandom_range(99) < 90;
            r.data = $urandom_range(99) < 75;
            r.single = 1'($urandom_range(1));
            r.w = $urandom_range(99) < 5 ? 12'($urandom) : 12'($urandom_range(1024));
            k = $urandom_range(99);
            r.h = k < 2 ? 12'($urandom)
                : k < 2 + tall_pct ? 12'($urandom_range(1168, 200)) : 12'($urandom_range(40));
            pending_reqs.push_back(r);
        end
    endtask

    task automatic set_idling(input int snd, input int rcv);
        send_idle = snd;
        recv_idle = rcv;
    endtask

    initial begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            tag_mem[i] = '0;
            mask_mem[i] = '0;
            row_mem[i] = '0;
        end
        for (int i = 0; i < MAX_PLANES; i++) high_water[i] = int'(BAND_BOTTOM);
        boundary = int'(BAND_TOP);
        all_mask = 24'hFF;
        plane_cnt = 5'd8;
        foreach (status_seen[i]) status_seen[i] = 0;
        // Half the pool maps onto one shared slot to force conflicts.
        for (int i = 0; i < 24; i++)
            id_pool[i] = i < 12 ? $urandom : {24'(i), 8'(i) ^ 8'hA5};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at default settings.
        push_req(REQ_CONFIRM, 32'd0, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0);
        push_req(REQ_CONFIRM, 32'h0000_1234, 1'b0, 1'b1, 1'b1, 12'd8, 12'd8);
        push_req(REQ_CONFIRM, 32'h0000_1234, 1'b1, 1'b1, 1'b1, 12'd1025, 12'd8);
        push_req(REQ_CONFIRM, 32'h0000_1234, 1'b1, 1'b1, 1'b1, 12'd8, 12'd1169);
        push_req(REQ_CONFIRM, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 12'hFFF, 12'hFFF);
        push_req(REQ_CONFIRM, 32'h0000_1234, 1'b1, 1'b1, 1'b1, 12'd1024, 12'd16);
        push_req(REQ_CONFIRM, 32'h0000_1234, 1'b1, 1'b1, 1'b1, 12'd1024, 12'd16);
        push_req(REQ_CONFIRM, 32'h00AB_CD00, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0);
        push_req(REQ_CONFIRM, 32'h00AB_CD01, 1'b1, 1'b0, 1'b0, 12'd64, 12'd32);
        push_req(REQ_CONFIRM, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 12'd1, 12'd1168);
        push_req(REQ_CONFIRM, 32'h5555_AAAA, 1'b1, 1'b1, 1'b1, 12'd1, 12'd1168);
        push_req(REQ_TEMP, 32'h0000_7777, 1'b1, 1'b1, 1'b1, 12'd10, 12'd10);
        push_req(REQ_CONFIRM, 32'h0000_7777, 1'b0, 1'b1, 1'b1, 12'd10, 12'd10);
        push_req(REQ_CANCEL, 32'h0000_1234, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0);
        push_req(REQ_CONFIRM, 32'h0000_1234, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0);
        push_req(REQ_CONFIRM, 32'hAAAA_5555, 1'b1, 1'b1, 1'b1, 12'd5, 12'd700);
        push_req(REQ_PURGE, 32'hAAAA_5555, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0);
        push_req(REQ_PURGE, 32'd0, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0);
        push_req(REQ_CONFIRM, 32'hAAAA_5555, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0);
        drain();

        // The receiver stops for a long stretch while requests keep coming.
        hold_req = 1;
        push_random(150, 6);
        drain();

        set_idling(80, 27);
        write_reg(CFG_ALL_PLANES, 24'hFFFFFF);
        write_reg(CFG_PLANE_CNT, 24'd24);
        push_random(150, 10);
        drain();

        set_idling(0, 0);
        write_reg(CFG_PLANE_CNT, 24'd31);
        push_random(100, 10);
        drain();

        // One plane whose mask is also the full-depth mask: space may not resolve.
        set_idling(27, 80);
        write_reg(CFG_ALL_PLANES, 24'h000001);
        write_reg(CFG_PLANE_CNT, 24'd1);
        push_random(100, 25);
        drain();

        set_idling(80, 27);
        write_reg(CFG_PLANE_CNT, 24'd0);
        write_reg(CFG_ALL_PLANES, 24'h000000);
        push_random(80, 15);
        drain();

        set_idling(0, 0);
        write_reg(CFG_ALL_PLANES, 24'h0000FF);
        write_reg(CFG_PLANE_CNT, 24'd3);
        push_random(150, 8);
        drain();

        $display("checked %0d requests over six register settings, incl. a long output stall",
                 accepted);
        $display("results: done %0d, hit %0d, load %0d, no data %0d, failed %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/opca_pkg.sv
rtl/opca_ram.sv
rtl/opca_ctrl.sv
rtl/opca_dpath.sv
rtl/offscreen_pixmap_cache_allocator_unit.sv
dv/tb_top.sv
